/* hw/rtl/playfair_digraph_encryptor_assert.svh */
// Assertion macros for the Playfair encryptor RTL.
// Each expects clk and arst_n in scope.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH

// Same-cycle implication.
`define PFE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfe assertion failed");

// Next-cycle implication.
`define PFE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfe assertion failed");

`endif

/* hw/rtl/pfe_pkg.sv */
package pfe_pkg;

	localparam int unsigned NUM_LETTERS = 26;
	localparam int unsigned SQ_CELLS    = 25;

	localparam logic [4:0] CODE_I = 5'd8;
	localparam logic [4:0] CODE_J = 5'd9;
	localparam logic [4:0] CODE_Z = 5'd25;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_KEY    = 3'd1;
	localparam logic [2:0] OP_FINISH = 3'd2;
	localparam logic [2:0] OP_TEXT   = 3'd3;
	localparam logic [2:0] OP_END    = 3'd4;

	// Row and column of each square position
	localparam logic [2:0] ROW_OF [SQ_CELLS] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4
	};
	localparam logic [2:0] COL_OF [SQ_CELLS] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4
	};

	typedef struct packed {
		logic clear;
		logic app_key;
		logic app_walk;
		logic walk_start;
		logic set_ready;
		logic pend_set;
		logic pair_start;
		logic end_start;
		logic rd_b;
		logic cap_pa;
		logic calc;
		logic rd_c2;
		logic cap_c1;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic pend_vld;
		logic letter_ok;
		logic walk_done;
		logic out_free;
	} sts_t;

	function automatic logic [2:0] inc5(input logic [2:0] x);
		logic [2:0] r;
		r = (x == 3'd4) ? 3'd0 : x + 3'd1;
		return r;
	endfunction

	function automatic logic [4:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
		logic [4:0] r;
		r = {row, 2'b00} + {2'b00, row} + {2'b00, col};
		return r;
	endfunction

endpackage

/* hw/rtl/pfe_ram.sv */
module pfe_ram #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/pfe_datapath.sv */
module pfe_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  pfe_pkg::cmd_t cmd,
	output pfe_pkg::sts_t sts,
	input  logic [4:0]    letter,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_data,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [4:0]    cipher_first,
	output logic [4:0]    cipher_second
);
	import pfe_pkg::*;

	logic [4:0]             filler_q;
	logic [NUM_LETTERS-1:0] used_q;
	logic [4:0]             fill_q;
	logic                   ready_q;
	logic [4:0]             pend_q;
	logic                   pend_vld_q;
	logic [4:0]             walk_q;
	logic                   out_vld_q;
	logic [4:0]             a_q, b_q, pa_q, idx1_q, idx2_q, c1_q;
	logic [4:0]             first_q, second_q;

	logic [4:0] letter_f, filler_c, filler_f, app_letter;
	logic       app_en, pend_eq, out_free;
	logic [4:0] pos_rdata, sq_rdata, pos_raddr, sq_raddr;
	logic [2:0] ra, ca, rb, cb;
	logic [4:0] idx1_d, idx2_d;

	assign letter_f = (letter == CODE_J) ? CODE_I : letter;
	assign filler_c = (filler_q > CODE_Z) ? CODE_Z : filler_q;
	assign filler_f = (filler_c == CODE_J) ? CODE_I : filler_c;
	assign pend_eq  = (pend_q == letter_f);
	assign out_free = !out_vld_q || !out_stall;

	// j never enters the square on the alphabet walk
	assign app_letter = cmd.app_walk ? walk_q : letter_f;
	assign app_en = (cmd.app_key || (cmd.app_walk && walk_q != CODE_J))
		&& (app_letter < 5'(NUM_LETTERS)) && !used_q[app_letter]
		&& (fill_q < 5'(SQ_CELLS));

	assign pos_raddr = cmd.rd_b ? b_q : a_q;
	assign sq_raddr  = cmd.rd_c2 ? idx2_q : idx1_q;

	pfe_ram #(.WIDTH(5), .DEPTH(NUM_LETTERS)) u_pos_ram (
		.clk   (clk),
		.we    (app_en),
		.waddr (app_letter),
		.wdata (fill_q),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	pfe_ram #(.WIDTH(5), .DEPTH(SQ_CELLS)) u_sq_ram (
		.clk   (clk),
		.we    (app_en),
		.waddr (fill_q),
		.wdata (app_letter),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	// Rectangle, row and column rules
	always_comb begin
		ra = ROW_OF[pa_q];
		ca = COL_OF[pa_q];
		rb = ROW_OF[pos_rdata];
		cb = COL_OF[pos_rdata];
		if (ra == rb) begin
			idx1_d = cell_idx(ra, inc5(ca));
			idx2_d = cell_idx(rb, inc5(cb));
		end else if (ca == cb) begin
			idx1_d = cell_idx(inc5(ra), ca);
			idx2_d = cell_idx(inc5(rb), cb);
		end else begin
			idx1_d = cell_idx(ra, cb);
			idx2_d = cell_idx(rb, ca);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q   <= CODE_Z;
			used_q     <= '0;
			fill_q     <= '0;
			ready_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			walk_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				filler_q <= cfg_data;
			end
			if (cmd.clear) begin
				used_q     <= '0;
				fill_q     <= '0;
				ready_q    <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (app_en) begin
					used_q[app_letter] <= 1'b1;
					fill_q             <= fill_q + 5'd1;
				end
				if (cmd.set_ready) begin
					ready_q <= 1'b1;
				end
				if (cmd.pend_set) begin
					pend_vld_q <= 1'b1;
				end else if (cmd.end_start || (cmd.pair_start && !pend_eq)) begin
					pend_vld_q <= 1'b0;
				end
			end
			if (cmd.walk_start) begin
				walk_q <= '0;
			end else if (cmd.app_walk) begin
				walk_q <= walk_q + 5'd1;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_set) begin
			pend_q <= letter_f;
		end
		if (cmd.pair_start) begin
			a_q <= pend_q;
			b_q <= pend_eq ? filler_f : letter_f;
		end else if (cmd.end_start) begin
			a_q <= pend_q;
			b_q <= filler_f;
		end
		if (cmd.cap_pa) begin
			pa_q <= pos_rdata;
		end
		if (cmd.calc) begin
			idx1_q <= idx1_d;
			idx2_q <= idx2_d;
		end
		if (cmd.cap_c1) begin
			c1_q <= sq_rdata;
		end
		if (cmd.load_out) begin
			first_q  <= c1_q;
			second_q <= sq_rdata;
		end
	end

	assign sts.ready     = ready_q;
	assign sts.pend_vld  = pend_vld_q;
	assign sts.letter_ok = (letter < 5'(NUM_LETTERS));
	assign sts.walk_done = (walk_q == 5'(NUM_LETTERS - 1));
	assign sts.out_free  = out_free;

	assign out_valid     = out_vld_q;
	assign cipher_first  = first_q;
	assign cipher_second = second_q;

endmodule

/* hw/rtl/pfe_ctrl.sv */
`include "playfair_digraph_encryptor_assert.svh"

module pfe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [2:0]    operation,
	input  pfe_pkg::sts_t sts,
	output logic          in_stall,
	output pfe_pkg::cmd_t cmd
);
	import pfe_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_RDB  = 3'd3;
	localparam logic [2:0] S_CALC = 3'd4;
	localparam logic [2:0] S_RC1  = 3'd5;
	localparam logic [2:0] S_RC2  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (operation)
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						OP_KEY: begin
							cmd.app_key = !sts.ready && sts.letter_ok;
						end
						OP_FINISH: begin
							cmd.walk_start = 1'b1;
							state_d        = S_WALK;
						end
						OP_TEXT: begin
							if (sts.ready && sts.letter_ok) begin
								if (!sts.pend_vld) begin
									cmd.pend_set = 1'b1;
								end else begin
									cmd.pair_start = 1'b1;
									state_d        = S_RDA;
								end
							end
						end
						OP_END: begin
							if (sts.ready && sts.pend_vld) begin
								cmd.end_start = 1'b1;
								state_d       = S_RDA;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				cmd.app_walk = 1'b1;
				if (sts.walk_done) begin
					cmd.set_ready = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RDA: begin
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.rd_b   = 1'b1;
				cmd.cap_pa = 1'b1;
				state_d    = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_RC1;
			end
			S_RC1: begin
				state_d = S_RC2;
			end
			S_RC2: begin
				cmd.rd_c2  = 1'b1;
				cmd.cap_c1 = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				// hold the second cell on the read port until the output frees
				cmd.rd_c2 = 1'b1;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PFE_ASSERT_NXT(a_walk_exit, state_q == S_WALK && sts.walk_done, state_q == S_IDLE)
	`PFE_ASSERT_NXT(a_pair_go, accept && operation == OP_TEXT && sts.ready && sts.letter_ok && sts.pend_vld, state_q == S_RDA)
	`PFE_ASSERT_IMP(a_out_load, state_q == S_OUT && sts.out_free, cmd.load_out)

endmodule

/* hw/rtl/playfair_digraph_encryptor.sv */
// Playfair encryptor over letter codes 0 to 25, j folded into i.
// Input channel: in_valid / in_stall with operation and letter; an item is
// taken when in_valid is high and in_stall low. Operations: clear key, key
// letter, finish key square, text letter, end of text.
// Output channel: out_valid / out_stall with cipher_first and cipher_second.
// Filler letter: cfg_valid / cfg_ready write port, always ready; write it
// only while the block is idle.
// Per item: clear, key letter and a text letter that only becomes pending
// are done in the idle state. Finish key walks the alphabet one letter a
// cycle into the square memories. An item that completes a pair passes
// through RDA and RDB (two reads of the position memory), CALC for the
// row/column rules, RC1 and RC2 (two reads of the square memory), all on
// single read ports, and OUT; out_valid rises once OUT loads the output.
// When out_stall holds a result, the next item is still taken; a second
// result waits in the final state until the output register frees.
// Reset clears the key square (not ready), any pending letter and the
// output, and sets the filler letter to z.
module playfair_digraph_encryptor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [4:0] letter,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] cipher_first,
	output logic [4:0] cipher_second,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] filler_letter
);
	import pfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	pfe_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.letter        (letter),
		.cfg_we        (cfg_valid),
		.cfg_data      (filler_letter),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.cipher_first  (cipher_first),
		.cipher_second (cipher_second)
	);

endmodule
